// ===== rtl/core/irpct_pkg.sv =====
// irpct_pkg: shared types, constants and register defaults for the IR pulse-code
// transmitter. No dependencies; imported by irpct_engine and the top level.
`timescale 1ns / 1ps

package irpct_pkg;

  localparam int MAX_BYTES_DEF   = 4;
  localparam int PULSE_LIMIT_DEF = 66;

  localparam int PIDX_W   = 7;   // pulse index width
  localparam int TICK_W   = 16;  // tick counter / duration width
  localparam int BYTE_W   = 8;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_START = 2'd2,
    ACT_TICK  = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEADER_ON  = 3'd0,
    CFG_LEADER_OFF = 3'd1,
    CFG_ONE_ON     = 3'd2,
    CFG_ONE_OFF    = 3'd3,
    CFG_ZERO_ON    = 3'd4,
    CFG_ZERO_OFF   = 3'd5
  } cfg_idx_t;

  localparam logic [TICK_W-1:0] LEADER_ON_RST  = 16'd9;
  localparam logic [TICK_W-1:0] LEADER_OFF_RST = 16'd4;
  localparam logic [TICK_W-1:0] ONE_ON_RST     = 16'd0;
  localparam logic [TICK_W-1:0] ONE_OFF_RST    = 16'd1;
  localparam logic [TICK_W-1:0] ZERO_ON_RST    = 16'd0;
  localparam logic [TICK_W-1:0] ZERO_OFF_RST   = 16'd0;

  typedef struct packed {
    logic [TICK_W-1:0] leader_on;
    logic [TICK_W-1:0] leader_off;
    logic [TICK_W-1:0] one_on;
    logic [TICK_W-1:0] one_off;
    logic [TICK_W-1:0] zero_on;
    logic [TICK_W-1:0] zero_off;
  } cfg_regs_t;

  typedef struct packed {
    logic strobe;
    logic ir_drive;
    logic busy_res;
    logic done_res;
  } result_t;

endpackage

// ===== rtl/core/irpct_engine.sv =====
// irpct_engine: message store, playback state and result register.
// Depends on irpct_pkg (action_t, cfg_regs_t, result_t).
`timescale 1ns / 1ps

module irpct_engine #(
  parameter int MAX_BYTES   = irpct_pkg::MAX_BYTES_DEF,
  parameter int PULSE_LIMIT = irpct_pkg::PULSE_LIMIT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  irpct_pkg::action_t            in_action,
  input  logic [irpct_pkg::BYTE_W-1:0]  in_data_byte,
  input  irpct_pkg::cfg_regs_t          cfg,
  output irpct_pkg::result_t            res
);
  import irpct_pkg::*;

  localparam int AW  = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int BCW = $clog2(MAX_BYTES + 1);
  localparam int EW  = BCW + 5;  // holds 2 + 16 * byte count
  localparam int SEL_W = 5;

  logic [BYTE_W-1:0] store_r [MAX_BYTES];

  logic [BCW-1:0]    byte_count_r, byte_count_nxt;
  logic              sending_r, sending_nxt;
  logic [PIDX_W-1:0] pulse_index_r, pulse_index_nxt;
  logic [TICK_W-1:0] tick_count_r, tick_count_nxt;
  logic              drive_r, drive_nxt;
  logic              done_r, done_nxt;
  logic              strobe_r;
  logic              store_we;

  logic [PIDX_W-1:0] p_minus2;
  logic [SEL_W-1:0]  byte_sel;
  logic [2:0]        bit_sel;
  logic [BYTE_W-1:0] sel_byte;
  logic              bit_val;
  logic              burst;
  logic [TICK_W-1:0] len;
  logic [EW-1:0]     end_mark;
  logic [PIDX_W:0]   pidx_inc;

  // current pulse: level and length
  always_comb begin
    p_minus2 = pulse_index_r - PIDX_W'(2);
    byte_sel = SEL_W'(p_minus2[PIDX_W-1:4]);
    bit_sel  = p_minus2[3:1];
    sel_byte = (byte_sel < SEL_W'(MAX_BYTES)) ? store_r[byte_sel[AW-1:0]] : '0;
    bit_val  = sel_byte[bit_sel];
    if (pulse_index_r < PIDX_W'(2)) begin
      burst = (pulse_index_r == '0);
      len   = burst ? cfg.leader_on : cfg.leader_off;
    end else begin
      burst = ~p_minus2[0];
      if (bit_val) len = burst ? cfg.one_on : cfg.one_off;
      else         len = burst ? cfg.zero_on : cfg.zero_off;
    end
    end_mark = EW'({byte_count_r, 4'b0000}) + EW'(2);
    pidx_inc = {1'b0, pulse_index_r} + (PIDX_W+1)'(1);
  end

  always_comb begin
    byte_count_nxt  = byte_count_r;
    sending_nxt     = sending_r;
    pulse_index_nxt = pulse_index_r;
    tick_count_nxt  = tick_count_r;
    drive_nxt       = drive_r;
    done_nxt        = 1'b0;
    store_we        = 1'b0;
    if (in_vld) begin
      unique case (in_action)
        ACT_CLEAR: begin
          if (!sending_r) byte_count_nxt = '0;
        end
        ACT_LOAD: begin
          if (!sending_r && byte_count_r < BCW'(MAX_BYTES)) begin
            store_we       = 1'b1;
            byte_count_nxt = byte_count_r + BCW'(1);
          end
        end
        ACT_START: begin
          if (!sending_r) begin
            pulse_index_nxt = '0;
            tick_count_nxt  = '0;
            sending_nxt     = 1'b1;
          end
        end
        ACT_TICK: begin
          if (sending_r) begin
            if (EW'(pulse_index_r) >= end_mark) begin
              sending_nxt     = 1'b0;
              drive_nxt       = 1'b0;
              pulse_index_nxt = '0;
              tick_count_nxt  = '0;
              done_nxt        = 1'b1;
            end else begin
              drive_nxt = burst;
              if (tick_count_r < len) begin
                tick_count_nxt = tick_count_r + TICK_W'(1);
              end else if (pidx_inc > (PIDX_W+1)'(PULSE_LIMIT)) begin
                // pulse limit passed: abort
                sending_nxt     = 1'b0;
                drive_nxt       = 1'b0;
                pulse_index_nxt = '0;
                tick_count_nxt  = '0;
                done_nxt        = 1'b1;
              end else begin
                pulse_index_nxt = pidx_inc[PIDX_W-1:0];
                tick_count_nxt  = '0;
              end
            end
          end
        end
        default: begin
          done_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r  <= '0;
      sending_r     <= 1'b0;
      pulse_index_r <= '0;
      tick_count_r  <= '0;
      drive_r       <= 1'b0;
      done_r        <= 1'b0;
      strobe_r      <= 1'b0;
    end else begin
      byte_count_r  <= byte_count_nxt;
      sending_r     <= sending_nxt;
      pulse_index_r <= pulse_index_nxt;
      tick_count_r  <= tick_count_nxt;
      drive_r       <= drive_nxt;
      done_r        <= done_nxt;
      strobe_r      <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[byte_count_r[AW-1:0]] <= in_data_byte;
    end
  end

  assign res.strobe   = strobe_r;
  assign res.ir_drive = drive_r;
  assign res.busy_res = sending_r;
  assign res.done_res = done_r;

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (!sending_r && !drive_r))
    else $error("done reported while still sending or driving");

  a_idle_counters: assert property (@(posedge clk) disable iff (!rst_n)
    !sending_r |-> (pulse_index_r == '0 && tick_count_r == '0))
    else $error("pulse counters not cleared while idle");

  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld |=> strobe_r)
    else $error("accepted word produced no result");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= BCW'(MAX_BYTES))
    else $error("byte count above store depth");

  a_done_only_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> strobe_r)
    else $error("done without a result strobe");

endmodule

// ===== rtl/core/ir_pulse_code_transmitter_top.sv =====
// ir_pulse_code_transmitter_top: command port, input register, config registers.
// Depends on irpct_pkg and irpct_engine.
// Result strobe: a command word passes the input register, then the engine's strobe register.
// Throughput: one word per cycle while busy is low; busy is high only in reset and the cycle after.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset (sync, rst_n low): store empty, idle, emitter off, config to defaults.
`timescale 1ns / 1ps

module ir_pulse_code_transmitter_top #(
  parameter int MAX_BYTES   = irpct_pkg::MAX_BYTES_DEF,
  parameter int PULSE_LIMIT = irpct_pkg::PULSE_LIMIT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       in_action,
  input  logic [irpct_pkg::BYTE_W-1:0]     in_data_byte,
  output logic                             out_strobe,
  output logic                             out_ir_drive,
  output logic                             out_busy_res,
  output logic                             out_done_res,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [irpct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [irpct_pkg::TICK_W-1:0]     cfg_data
);
  import irpct_pkg::*;

  logic              busy_r;
  logic              in_vld_r;
  logic [1:0]        in_action_r;
  logic [BYTE_W-1:0] in_data_r;
  cfg_regs_t         cfg_r, cfg_nxt;
  result_t           res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b1;
      in_vld_r <= 1'b0;
    end else begin
      busy_r   <= 1'b0;
      in_vld_r <= start & ~busy_r;
    end
  end

  always_ff @(posedge clk) begin
    in_action_r <= in_action;
    in_data_r   <= in_data_byte;
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LEADER_ON:  cfg_nxt.leader_on  = cfg_data;
        CFG_LEADER_OFF: cfg_nxt.leader_off = cfg_data;
        CFG_ONE_ON:     cfg_nxt.one_on     = cfg_data;
        CFG_ONE_OFF:    cfg_nxt.one_off    = cfg_data;
        CFG_ZERO_ON:    cfg_nxt.zero_on    = cfg_data;
        CFG_ZERO_OFF:   cfg_nxt.zero_off   = cfg_data;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.leader_on  <= LEADER_ON_RST;
      cfg_r.leader_off <= LEADER_OFF_RST;
      cfg_r.one_on     <= ONE_ON_RST;
      cfg_r.one_off    <= ONE_OFF_RST;
      cfg_r.zero_on    <= ZERO_ON_RST;
      cfg_r.zero_off   <= ZERO_OFF_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  irpct_engine #(
    .MAX_BYTES   (MAX_BYTES),
    .PULSE_LIMIT (PULSE_LIMIT)
  ) u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_vld       (in_vld_r),
    .in_action    (action_t'(in_action_r)),
    .in_data_byte (in_data_r),
    .cfg          (cfg_r),
    .res          (res)
  );

  assign busy         = busy_r;
  assign cfg_ready    = 1'b1;
  assign out_strobe   = res.strobe;
  assign out_ir_drive = res.ir_drive;
  assign out_busy_res = res.busy_res;
  assign out_done_res = res.done_res;

endmodule
